// File: rtl/core/ttc_pkg.sv
// Shared types and constants for the timestamp to tick converter.
// Holds the channel payload structs, the controller states and the
// command and status bundles. No dependencies.
`timescale 1ns / 1ps

package ttc_pkg;

  typedef struct packed {
    logic [31:0] seconds;
    logic [29:0] nanoseconds;
  } ttc_in_t;

  typedef struct packed {
    logic [63:0] tick_count;
    logic        went_backward;
  } ttc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_UPDATE,
    ST_CLAMP,
    ST_SUM,
    ST_DIVIDE,
    ST_COMMIT,
    ST_EMIT
  } ttc_state_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic update;
    logic clamp;
    logic sum;
    logic div_step;
    logic commit;
    logic emit;
  } ttc_cmd_t;

  typedef struct packed {
    logic out_free;
  } ttc_status_t;

  localparam logic [29:0] NS_MAX      = 30'd999999999;
  localparam logic [30:0] NS_PER_SEC  = 31'd1000000000;
  localparam logic [30:0] AVG_RESET   = 31'd1000000000;
  localparam logic [29:0] SLICE_100MS = 30'd100000000;
  localparam logic [29:0] SLICE_1S    = 30'd1000000000;

  localparam int                   DIV_STEPS = 32;
  localparam int                   DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

endpackage

// File: rtl/core/ttc_datapath.sv
// Datapath of the timestamp to tick converter: tracking state, step
// averaging, the radix-4 divider by the tick length and the output register.
// Depends on ttc_pkg; driven by commands from ttc_controller.
`timescale 1ns / 1ps

module ttc_datapath
  import ttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ttc_in_t     in_data,
  input  logic        cfg_valid,
  input  logic        cfg_data,
  input  logic        out_ready,
  input  ttc_cmd_t    cmd,
  output ttc_status_t status,
  output logic        out_valid,
  output ttc_out_t    out_data
);

  logic        tick_mode_r;
  logic [31:0] cur_sec_r;
  logic [29:0] cur_ns_r;
  logic [31:0] last_sec_r;
  logic [29:0] last_ns_r;
  logic [30:0] avg_r;
  logic [63:0] rem_r;
  logic [63:0] total_r;
  logic [30:0] step_r;
  logic        back_r;
  logic        skip_en_r;
  logic [31:0] skip_r;
  logic [63:0] div_r;
  logic [29:0] prem_r;
  logic        out_valid_r;
  ttc_out_t    out_data_r;

  logic [29:0] ns_sat;
  logic [29:0] slice;
  logic [31:0] sec_diff;
  logic        same_fwd;
  logic        later;
  logic [35:0] skip_scaled;
  logic [34:0] avg_sum;
  logic [30:0] avg_nxt;
  logic [32:0] avg3;
  logic [30:0] p1;
  logic        ge1;
  logic [30:0] r1;
  logic [30:0] p2;
  logic        ge2;
  logic [30:0] r2;

  always_comb begin
    ns_sat      = (in_data.nanoseconds > NS_MAX) ? NS_MAX : in_data.nanoseconds;
    slice       = tick_mode_r ? SLICE_1S : SLICE_100MS;
    sec_diff    = cur_sec_r - last_sec_r;
    same_fwd    = (cur_sec_r == last_sec_r) && (cur_ns_r >= last_ns_r);
    later       = cur_sec_r > last_sec_r;
    skip_scaled = tick_mode_r ? {4'b0, skip_r}
                              : ({1'b0, skip_r, 3'b0} + {3'b0, skip_r, 1'b0});
    avg_sum     = {1'b0, avg_r, 3'b0} - {4'b0, avg_r} + {4'b0, step_r};
    avg_nxt     = avg_sum[33:3];
    avg3        = {2'b0, avg_r} + {1'b0, avg_r, 1'b0};
    p1          = {prem_r, div_r[63]};
    ge1         = p1 >= {1'b0, slice};
    r1          = ge1 ? (p1 - {1'b0, slice}) : p1;
    p2          = {r1[29:0], div_r[62]};
    ge2         = p2 >= {1'b0, slice};
    r2          = ge2 ? (p2 - {1'b0, slice}) : p2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_mode_r <= 1'b0;
      last_sec_r  <= '0;
      last_ns_r   <= '0;
      avg_r       <= AVG_RESET;
      rem_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tick_mode_r <= cfg_data;
      end
      if (cmd.classify && !same_fwd && !later) begin
        rem_r <= rem_r + {33'b0, avg_r};
      end
      if (cmd.update) begin
        if (skip_en_r) begin
          total_r    <= total_r + {28'b0, skip_scaled};
          last_sec_r <= cur_sec_r;
        end
        if (!back_r) begin
          avg_r <= avg_nxt;
        end
      end
      if (cmd.commit && (div_r != '0)) begin
        total_r    <= total_r + div_r;
        last_sec_r <= cur_sec_r;
        last_ns_r  <= cur_ns_r;
        rem_r      <= {34'b0, prem_r};
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_sec_r <= in_data.seconds;
      cur_ns_r  <= ns_sat;
    end
    if (cmd.classify) begin
      if (same_fwd) begin
        step_r    <= {1'b0, cur_ns_r - last_ns_r};
        back_r    <= 1'b0;
        skip_en_r <= 1'b0;
      end else if (later) begin
        step_r    <= {1'b0, cur_ns_r} + NS_PER_SEC - {1'b0, last_ns_r};
        back_r    <= 1'b0;
        skip_en_r <= sec_diff > 32'd1;
      end else begin
        step_r    <= '0;
        back_r    <= 1'b1;
        skip_en_r <= 1'b0;
      end
      skip_r <= sec_diff - 32'd1;
    end
    if (cmd.clamp && ({2'b0, step_r} > avg3)) begin
      step_r <= avg_r;
    end
    if (cmd.sum) begin
      div_r  <= {33'b0, step_r} + rem_r;
      prem_r <= '0;
    end
    if (cmd.div_step) begin
      div_r  <= {div_r[61:0], ge1, ge2};
      prem_r <= r2[29:0];
    end
    if (cmd.emit) begin
      out_data_r.tick_count    <= total_r;
      out_data_r.went_backward <= back_r;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// File: rtl/core/ttc_controller.sv
// Sequencing state machine of the timestamp to tick converter.
// Steps each transaction through classify, update, clamp, sum, divide,
// commit and emit. Depends on ttc_pkg.
`timescale 1ns / 1ps

module ttc_controller
  import ttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ttc_status_t status,
  output ttc_cmd_t    cmd
);

  ttc_state_t           state_r;
  ttc_state_t           state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cnt_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CLASSIFY: cmd.classify = 1'b1;
      ST_UPDATE:   cmd.update = 1'b1;
      ST_CLAMP:    cmd.clamp = 1'b1;
      ST_SUM:      cmd.sum = 1'b1;
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      ST_COMMIT:   cmd.commit = 1'b1;
      ST_EMIT:     cmd.emit = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/timestamp_to_tick_converter.sv
// Top level of the timestamp to tick converter.
// Instantiates ttc_controller and ttc_datapath; depends on ttc_pkg.
//
// Usage: a timestamp transaction (seconds, nanoseconds) enters on the in_
// channel and yields exactly one result transaction on the out_ channel
// carrying the running tick count and a flag for a backward timestamp.
// The cfg_ channel writes the tick mode (0 for 100 ms, 1 for 1 s ticks);
// it is always ready and should be written only while the block is idle.
// One transaction is processed at a time. The result becomes valid after
// seven control steps and the divider by the tick length, which resolves
// two quotient bits per cycle; the next timestamp is accepted once the
// result is in the output register.
// A finished result waits in the output register; while the receiver
// stalls, a following timestamp is still accepted and processed, and it
// holds only at its final step until the output register frees.
// Synchronous reset clears the tick count, the remainder and the last
// timestamp, sets the average step to one second and selects 100 ms ticks.
`timescale 1ns / 1ps

module timestamp_to_tick_converter
  import ttc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ttc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ttc_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  ttc_cmd_t    cmd;
  ttc_status_t status;

  assign cfg_ready = 1'b1;

  ttc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ttc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: dv/ttc_tick_checker.sv
// Tick count checker for the timestamp to tick converter.
// Watches the timestamp, result and tick mode channels, predicts every result
// and compares it field by field. Depends on ttc_pkg.
`timescale 1ns / 1ps

module ttc_tick_checker
  import ttc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ttc_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  ttc_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic     cfg_data,
  output int       mismatches,
  output int       results_due
);

  localparam logic [63:0] NS_SEC    = 64'd1000000000;
  localparam logic [63:0] NS_TOP    = 64'd999999999;
  localparam logic [63:0] TENTH_SEC = 64'd100000000;

  logic        mode_1s;
  logic [31:0] seen_sec;
  logic [29:0] seen_ns;
  logic [30:0] avg_step;
  logic [63:0] rem_ns;
  logic [63:0] ticks;
  ttc_out_t    counts_due[$];
  ttc_out_t    want;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic ttc_out_t next_tick_result(ttc_in_t stamp);
    logic [63:0] slice;
    logic [63:0] ns;
    logic [63:0] step;
    logic [63:0] total;
    logic [63:0] sec_gap;
    ttc_out_t    res;
    slice = mode_1s ? NS_SEC : TENTH_SEC;
    ns = (64'(stamp.nanoseconds) > NS_TOP) ? NS_TOP : 64'(stamp.nanoseconds);
    res.went_backward = 1'b0;
    if (stamp.seconds == seen_sec && ns >= 64'(seen_ns)) begin
      step = ns - 64'(seen_ns);
      avg_step = 31'((64'd7 * 64'(avg_step) + step) >> 3);
    end else if (stamp.seconds > seen_sec) begin
      step = ns + NS_SEC - 64'(seen_ns);
      sec_gap = 64'(stamp.seconds) - 64'(seen_sec);
      if (sec_gap > 64'd1) begin
        ticks += (sec_gap - 64'd1) * (NS_SEC / slice);
        seen_sec = stamp.seconds;
      end
      avg_step = 31'((64'd7 * 64'(avg_step) + step) >> 3);
    end else begin
      res.went_backward = 1'b1;
      rem_ns += 64'(avg_step);
      step = 64'd0;
    end
    if (step > 64'd3 * 64'(avg_step)) begin
      step = 64'(avg_step);
    end
    total = step + rem_ns;
    if (total >= slice) begin
      ticks += total / slice;
      seen_sec = stamp.seconds;
      seen_ns = ns[29:0];
      rem_ns = total % slice;
    end
    res.tick_count = ticks;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_1s = 1'b0;
      seen_sec = '0;
      seen_ns = '0;
      avg_step = AVG_RESET;
      rem_ns = '0;
      ticks = '0;
      counts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_1s = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (counts_due.size() == 0) begin
          $error("Result transaction with no timestamp outstanding: tick_count %0d",
                 out_data.tick_count);
          mismatches++;
        end else begin
          want = counts_due.pop_front();
          if (out_data.tick_count !== want.tick_count) begin
            $error("tick_count mismatch: expected %0d, got %0d",
                   want.tick_count, out_data.tick_count);
            mismatches++;
          end
          if (out_data.went_backward !== want.went_backward) begin
            $error("went_backward mismatch: expected %0b, got %0b",
                   want.went_backward, out_data.went_backward);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        counts_due.push_back(next_tick_result(in_data));
      end
    end
    results_due <= counts_due.size();
  end

endmodule

// File: dv/timestamp_to_tick_converter_tb.sv
// Testbench top for the timestamp to tick converter.
// Drives timestamps and tick mode writes, stalls the result side at random and
// gives the verdict; depends on ttc_pkg, ttc_tick_checker and the RTL.
`timescale 1ns / 1ps

module timestamp_to_tick_converter_tb;
  import ttc_pkg::*;

  localparam logic [63:0] NS_SEC = 64'd1000000000;
  localparam logic [29:0] NS_TOP = 30'd999999999;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ttc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ttc_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  int mismatches;
  int results_due;

  logic stamp_taken = 1'b0;
  logic mode_taken = 1'b0;
  logic out_taken = 1'b0;
  int   out_hold = 0;
  int   out_calm = 0;
  int   in_calm = 0;
  int   sent = 0;
  int   mode_writes = 0;

  logic [31:0] cur_sec = '0;
  logic [29:0] cur_ns = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timestamp_to_tick_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ttc_tick_checker tick_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always @(posedge clk) begin
    stamp_taken <= in_valid && in_ready;
    mode_taken <= cfg_valid && cfg_ready;
    out_taken <= out_valid && out_ready;
    if (out_valid && out_ready) begin
      if (out_calm > 0) begin
        out_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        out_calm = $urandom_range(10, 40);
      end
      out_hold = $urandom_range(0, 10);
    end
  end

  always @(negedge clk) begin
    if (out_calm > 0) begin
      out_ready <= 1'b1;
    end else if (!out_valid || out_taken) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer_stamp(input logic [31:0] sec, input logic [29:0] ns);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      in_calm = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{seconds: sec, nanoseconds: ns};
    do @(negedge clk); while (!stamp_taken);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(negedge clk); while (!mode_taken);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic move_cursor(input logic [63:0] add_ns);
    logic [63:0] t;
    logic [63:0] s;
    t = 64'(cur_ns) + add_ns;
    s = 64'(cur_sec) + t / NS_SEC;
    if (s > 64'hFFFF_FFFF) begin
      cur_sec = $urandom_range(0, 1000);
      cur_ns = 30'($urandom_range(0, 999_999_999));
    end else begin
      cur_sec = s[31:0];
      cur_ns = 30'(t % NS_SEC);
    end
  endtask

  task automatic step_back(input logic [63:0] sub_ns);
    logic [63:0] t;
    t = 64'(cur_sec) * NS_SEC + 64'(cur_ns);
    t = (t >= sub_ns) ? t - sub_ns : 64'd0;
    cur_sec = 32'(t / NS_SEC);
    cur_ns = 30'(t % NS_SEC);
  endtask

  // A long run of one timestamp decays the average step to zero, after which
  // tiny forward steps are all clamped to nothing.
  task automatic hold_burst();
    int n;
    if (cur_sec > 32'hFFFF_FF00) begin
      cur_sec = 32'd1000;
    end
    cur_sec += 32'd2;
    cur_ns = NS_TOP;
    for (n = 0; n < 181; n++) begin
      offer_stamp(cur_sec, cur_ns);
    end
    for (n = 0; n < 3; n++) begin
      offer_stamp(cur_sec + 32'd1, 30'($urandom_range(0, 6)));
    end
    cur_sec += 32'd1;
    cur_ns = 30'd6;
  endtask

  task automatic random_phase(input int count, input bit with_burst);
    int n;
    int kind;
    int burst_at;
    burst_at = with_burst ? int'($urandom_range(0, count - 1)) : -1;
    for (n = 0; n < count; n++) begin
      if (n == burst_at) begin
        hold_burst();
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        move_cursor(64'($urandom_range(0, 300_000_000)));
      end else if (kind < 55) begin
        move_cursor(64'($urandom_range(700_000_000, 1_300_000_000)));
      end else if (kind < 63) begin
        move_cursor(64'($urandom_range(2, 30)) * NS_SEC
                    + 64'($urandom_range(0, 999_999_999)));
      end else if (kind < 65) begin
        cur_sec = $urandom_range(cur_sec, 32'hFFFF_FFFF);
        cur_ns = 30'($urandom_range(0, 999_999_999));
      end else if (kind < 75) begin
        step_back(64'($urandom_range(0, 500_000_000)));
      end else if (kind < 78) begin
        cur_sec = $urandom_range(0, cur_sec);
        cur_ns = 30'($urandom_range(0, 999_999_999));
      end
      if (kind < 84) begin
        offer_stamp(cur_sec, cur_ns);
      end else if (kind < 90) begin
        offer_stamp(cur_sec, 30'($urandom_range(1_000_000_000, 32'h3FFF_FFFF)));
      end else begin
        offer_stamp($urandom(), 30'($urandom()));
      end
    end
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    offer_stamp(32'd0, 30'd0);
    offer_stamp(32'd0, 30'd50_000_000);
    offer_stamp(32'd0, 30'd150_000_000);
    offer_stamp(32'd0, 30'h3FFF_FFFF);
    offer_stamp(32'd0, 30'd1_000_000_000);
    offer_stamp(32'd1, 30'd0);
    offer_stamp(32'd5, 30'd500_000_000);
    offer_stamp(32'd3, 30'd0);
    offer_stamp(32'd5, 30'd100);
    offer_stamp(32'd6, NS_TOP);
    offer_stamp(32'd100, 30'd0);
    offer_stamp(32'hFFFF_FFF0, 30'd0);
    offer_stamp(32'hFFFF_FFFF, NS_TOP);
    offer_stamp(32'hFFFF_FFFF, NS_TOP);
    offer_stamp(32'd0, 30'd0);
    drain_results();

    write_mode(1'b1);
    offer_stamp(32'hFFFF_FFFF, 30'h3FFF_FFFF);
    offer_stamp(32'd10, 30'd0);
    offer_stamp(32'd10, 30'd0);
    offer_stamp(32'd12, 30'd300_000_000);
    offer_stamp(32'd12, 30'd300_000_001);
    offer_stamp(32'd13, 30'd0);
    drain_results();

    cur_sec = 32'd20;
    cur_ns = 30'd0;
    for (ph = 0; ph < 6; ph++) begin
      write_mode(ph % 2 == 1);
      random_phase(230, ph % 2 == 0);
      drain_results();
    end

    repeat (40) @(negedge clk);
    $display("Ran %0d timestamp transactions across %0d tick mode writes,", sent, mode_writes);
    $display("with forward, backward, skipped-second and out-of-range stamps.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
